@@ sv/cmpmp_pkg.sv @@
`timescale 1ns / 1ps

package cmpmp_pkg;

  localparam int unsigned DIM_DEF = 9;

  localparam int unsigned RC_W    = 4;
  localparam int unsigned STEPS_W = 28;
  localparam int unsigned WAYS_W  = 30;

  localparam logic [STEPS_W-1:0] INF_STEPS = 28'd200000000;
  localparam logic [WAYS_W-1:0]  WAYS_MOD  = 30'd1000000007;

  // Barrett constant floor(2^60 / WAYS_MOD), fits in 31 bits
  localparam logic [63:0] BARRETT_FULL = (64'd1 << 60) / 64'd1000000007;
  localparam logic [30:0] BARRETT_M    = 31'(BARRETT_FULL);

  // stages from memory output register to accumulator write
  localparam int unsigned MAC_LAT = 7;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_MUL   = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_RESET = 2'd3
  } func_e;

  typedef struct packed {
    logic [STEPS_W-1:0] steps;
    logic [WAYS_W-1:0]  ways;
  } elem_t;

  localparam elem_t ELEM_ZERO = '{steps: INF_STEPS, ways: '0};
  localparam elem_t ELEM_ONE  = '{steps: '0, ways: 30'd1};

  typedef struct packed {
    func_e              func;
    logic [RC_W-1:0]    row;
    logic [RC_W-1:0]    col;
    logic [STEPS_W-1:0] steps_in;
    logic [WAYS_W-1:0]  ways_in;
  } req_t;

  typedef struct packed {
    logic [STEPS_W-1:0] steps_out;
    logic [WAYS_W-1:0]  ways_out;
  } rsp_t;

  // tag riding along with one multiply-accumulate
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_tag_t;

endpackage

@@ sv/counting_min_plus_matrix_product_unit.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// --------  ---------  -------------------------  --------------------------
// request   in         start high, busy low       req_i : func row col
//                                                  steps_in ways_in
// response  out        rsp_valid_o, one cycle     rsp_o : steps_out ways_out
//
// Load, reset and read words leave busy low.
// A read result is registered in the product read port, then in rsp_q.
// A multiply word holds busy while one shared multiply-accumulate unit
// takes one operand pair per cycle from the one read port of each matrix
// memory, and then while the pipeline drains.
// Reset is immediate: valid bits give the reset contents, no clearing pass.
// The receiver cannot stall; each result is shown for exactly one cycle.

module counting_min_plus_matrix_product_unit import cmpmp_pkg::*; #(
  parameter int unsigned DIM = DIM_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  localparam int unsigned    A_W    = $clog2(DIM * DIM);
  localparam logic [RC_W:0]  DIM_RC = (RC_W + 1)'(DIM);

  logic           acc_word;
  logic           idx_ok;
  logic           rd_acc;
  logic [A_W-1:0] req_addr;
  elem_t          ld_elem;

  // sequencer side
  logic           seq_bank;
  mac_tag_t       seq_tag;
  logic           seq_diag;
  logic [A_W-1:0] seq_op_addr;
  logic [A_W-1:0] seq_pr_addr;
  logic [A_W-1:0] seq_dst_addr;

  // store side
  elem_t          op_elem;
  elem_t          pr_elem;
  logic           pr_rd_en;
  logic [A_W-1:0] pr_rd_addr;
  logic           pr_rd_diag;

  // accumulator write
  logic           mac_wr_en;
  logic [A_W-1:0] mac_wr_addr;
  elem_t          mac_wr_data;

  // read response path
  logic  rd_pend_q;
  logic  rd_oob_q;
  logic  rsp_valid_q;
  rsp_t  rsp_q;
  rsp_t  rsp_d;

  assign acc_word = start && !busy;
  assign idx_ok   = ({1'b0, req_i.row} < DIM_RC) && ({1'b0, req_i.col} < DIM_RC);
  assign req_addr = A_W'(req_i.row * DIM + req_i.col);
  assign rd_acc   = acc_word && (req_i.func == FUNC_READ);

  // loaded entries are clamped / reduced on the way in
  assign ld_elem.steps = (req_i.steps_in > INF_STEPS) ? INF_STEPS : req_i.steps_in;
  assign ld_elem.ways  = (req_i.ways_in >= WAYS_MOD) ? req_i.ways_in - WAYS_MOD
                                                     : req_i.ways_in;

  cmpmp_seq #(.DIM(DIM)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (acc_word && (req_i.func == FUNC_MUL)),
    .busy_o      (busy),
    .bank_o      (seq_bank),
    .tag_o       (seq_tag),
    .diag_o      (seq_diag),
    .op_addr_o   (seq_op_addr),
    .prod_addr_o (seq_pr_addr),
    .dst_addr_o  (seq_dst_addr)
  );

  // product read port: sequencer while multiplying, else read words
  assign pr_rd_en   = seq_tag.vld || (rd_acc && idx_ok);
  assign pr_rd_addr = seq_tag.vld ? seq_pr_addr : req_addr;
  assign pr_rd_diag = seq_tag.vld ? seq_diag : (req_i.row == req_i.col);

  cmpmp_store #(.DIM(DIM)) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_wr_en_i   (acc_word && (req_i.func == FUNC_LOAD) && idx_ok),
    .op_wr_addr_i (req_addr),
    .op_wr_data_i (ld_elem),
    .op_rd_en_i   (seq_tag.vld),
    .op_rd_addr_i (seq_op_addr),
    .op_rd_o      (op_elem),
    .pr_clr_i     (acc_word && (req_i.func == FUNC_RESET)),
    .pr_wr_en_i   (mac_wr_en),
    .pr_wr_bank_i (~seq_bank),
    .pr_wr_addr_i (mac_wr_addr),
    .pr_wr_data_i (mac_wr_data),
    .pr_rd_en_i   (pr_rd_en),
    .pr_rd_bank_i (seq_bank),
    .pr_rd_addr_i (pr_rd_addr),
    .pr_rd_diag_i (pr_rd_diag),
    .pr_rd_o      (pr_elem)
  );

  // new product goes to the idle bank; banks swap at end of drain
  cmpmp_mac #(.DIM(DIM)) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tag_i     (seq_tag),
    .dst_i     (seq_dst_addr),
    .op_i      (op_elem),
    .prod_i    (pr_elem),
    .wr_en_o   (mac_wr_en),
    .wr_addr_o (mac_wr_addr),
    .wr_data_o (mac_wr_data)
  );

  // out-of-range reads answer with the semiring zero
  always_comb begin
    rsp_d.steps_out = rd_oob_q ? INF_STEPS : pr_elem.steps;
    rsp_d.ways_out  = rd_oob_q ? '0 : pr_elem.ways;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      rd_pend_q   <= rd_acc;
      rsp_valid_q <= rd_pend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_oob_q <= !idx_ok;
    if (rd_pend_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTHESIS
  a_read_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_acc |-> ##2 rsp_valid_o)
    else $error("read word got no response");

  a_no_stray_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(rd_acc, 2))
    else $error("response without a read word");
`endif

endmodule

@@ sv/cmpmp_store.sv @@
`timescale 1ns / 1ps

module cmpmp_store import cmpmp_pkg::*; #(
  parameter  int unsigned DIM  = DIM_DEF,
  localparam int unsigned N    = DIM * DIM,
  localparam int unsigned A_W  = $clog2(N),
  localparam int unsigned PA_W = $clog2(2 * N)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // operand matrix
  input  logic           op_wr_en_i,
  input  logic [A_W-1:0] op_wr_addr_i,
  input  elem_t          op_wr_data_i,
  input  logic           op_rd_en_i,
  input  logic [A_W-1:0] op_rd_addr_i,
  output elem_t          op_rd_o,
  // product matrix, two banks
  input  logic           pr_clr_i,
  input  logic           pr_wr_en_i,
  input  logic           pr_wr_bank_i,
  input  logic [A_W-1:0] pr_wr_addr_i,
  input  elem_t          pr_wr_data_i,
  input  logic           pr_rd_en_i,
  input  logic           pr_rd_bank_i,
  input  logic [A_W-1:0] pr_rd_addr_i,
  input  logic           pr_rd_diag_i,
  output elem_t          pr_rd_o
);

  elem_t op_mem [N];
  elem_t pr_mem [2*N];

  elem_t op_rd_q;
  elem_t pr_rd_q;

  logic [N-1:0]   op_vld_q;
  logic [2*N-1:0] pr_vld_q;
  logic           op_vld_rd_q;
  logic           pr_vld_rd_q;
  logic           pr_diag_q;

  logic [PA_W-1:0] pr_wr_idx;
  logic [PA_W-1:0] pr_rd_idx;

  assign pr_wr_idx = pr_wr_bank_i ? PA_W'(N) + PA_W'(pr_wr_addr_i) : PA_W'(pr_wr_addr_i);
  assign pr_rd_idx = pr_rd_bank_i ? PA_W'(N) + PA_W'(pr_rd_addr_i) : PA_W'(pr_rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (op_wr_en_i) begin
      op_mem[op_wr_addr_i] <= op_wr_data_i;
    end
    if (op_rd_en_i) begin
      op_rd_q <= op_mem[op_rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pr_wr_en_i) begin
      pr_mem[pr_wr_idx] <= pr_wr_data_i;
    end
    if (pr_rd_en_i) begin
      pr_rd_q <= pr_mem[pr_rd_idx];
    end
  end

  // valid bits stand in for the reset contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_vld_q    <= '0;
      pr_vld_q    <= '0;
      op_vld_rd_q <= 1'b0;
      pr_vld_rd_q <= 1'b0;
      pr_diag_q   <= 1'b0;
    end else begin
      if (op_wr_en_i) begin
        op_vld_q[op_wr_addr_i] <= 1'b1;
      end
      if (pr_clr_i) begin
        pr_vld_q <= '0;
      end else if (pr_wr_en_i) begin
        pr_vld_q[pr_wr_idx] <= 1'b1;
      end
      if (op_rd_en_i) begin
        op_vld_rd_q <= op_vld_q[op_rd_addr_i];
      end
      if (pr_rd_en_i) begin
        pr_vld_rd_q <= pr_vld_q[pr_rd_idx];
        pr_diag_q   <= pr_rd_diag_i;
      end
    end
  end

  assign op_rd_o = op_vld_rd_q ? op_rd_q : ELEM_ZERO;
  assign pr_rd_o = pr_vld_rd_q ? pr_rd_q : (pr_diag_q ? ELEM_ONE : ELEM_ZERO);

endmodule

@@ sv/cmpmp_mac.sv @@
`timescale 1ns / 1ps

module cmpmp_mac import cmpmp_pkg::*; #(
  parameter  int unsigned DIM = DIM_DEF,
  localparam int unsigned A_W = $clog2(DIM * DIM)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // issue cycle
  input  mac_tag_t       tag_i,
  input  logic [A_W-1:0] dst_i,
  // the cycle after issue
  input  elem_t          op_i,
  input  elem_t          prod_i,
  // result write
  output logic           wr_en_o,
  output logic [A_W-1:0] wr_addr_o,
  output elem_t          wr_data_o
);

  function automatic elem_t sr_add(elem_t a, elem_t b);
    elem_t             r;
    logic [WAYS_W:0]   w;
    w = {1'b0, a.ways} + {1'b0, b.ways};
    if (a.steps < b.steps) begin
      r = a;
    end else if (a.steps > b.steps) begin
      r = b;
    end else begin
      r.steps = a.steps;
      r.ways  = (w >= {1'b0, WAYS_MOD}) ? WAYS_W'(w - {1'b0, WAYS_MOD}) : w[WAYS_W-1:0];
    end
    return r;
  endfunction

  mac_tag_t           tag_q [MAC_LAT];
  logic [A_W-1:0]     dst_q [MAC_LAT];
  logic [STEPS_W-1:0] st_q  [MAC_LAT-1];

  logic [STEPS_W:0]   st_sum;
  logic [STEPS_W-1:0] st_d;
  logic [59:0]        x_d;
  logic [61:0]        t_d;
  logic [31:0]        qp_d;
  logic [31:0]        r4_d;
  logic [31:0]        r5_d;
  logic [30:0]        r6_d;

  logic [59:0] x_q;
  logic [30:0] q_q;
  logic [31:0] xlo2_q;
  logic [31:0] qp_q;
  logic [31:0] xlo3_q;
  logic [31:0] r4_q;
  logic [30:0] r5_q;
  logic [29:0] r6_q;

  elem_t acc_q;
  elem_t in_e;
  elem_t acc_d;

  // stage 1: step sum with saturation, raw way product
  assign st_sum = {1'b0, op_i.steps} + {1'b0, prod_i.steps};
  assign st_d   = (st_sum > {1'b0, INF_STEPS}) ? INF_STEPS : st_sum[STEPS_W-1:0];
  assign x_d    = op_i.ways * prod_i.ways;

  // stage 2: Barrett quotient estimate
  assign t_d  = x_q[59:29] * BARRETT_M;
  // stage 3: quotient times modulus, low word only
  assign qp_d = 32'(q_q) * 32'(WAYS_MOD);
  // stage 4: remainder below 3 * modulus
  assign r4_d = xlo3_q - qp_q;
  // stages 5 and 6: two conditional subtracts
  assign r5_d = (r4_q >= 32'(WAYS_MOD)) ? r4_q - 32'(WAYS_MOD) : r4_q;
  assign r6_d = (r5_q >= 31'(WAYS_MOD)) ? r5_q - 31'(WAYS_MOD) : r5_q;

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    q_q    <= t_d[61:31];
    xlo2_q <= x_q[31:0];
    qp_q   <= qp_d;
    xlo3_q <= xlo2_q;
    r4_q   <= r4_d;
    r5_q   <= r5_d[30:0];
    r6_q   <= r6_d[29:0];
    st_q[0]  <= st_d;
    dst_q[0] <= dst_i;
    for (int s = 1; s < MAC_LAT - 1; s++) begin
      st_q[s] <= st_q[s-1];
    end
    for (int s = 1; s < MAC_LAT; s++) begin
      dst_q[s] <= dst_q[s-1];
    end
    if (tag_q[MAC_LAT-1].vld) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < MAC_LAT; s++) begin
        tag_q[s] <= '0;
      end
    end else begin
      tag_q[0] <= tag_i;
      for (int s = 1; s < MAC_LAT; s++) begin
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  // accumulate along k, first term starts fresh
  assign in_e  = '{steps: st_q[MAC_LAT-2], ways: r6_q};
  assign acc_d = tag_q[MAC_LAT-1].first ? in_e : sr_add(acc_q, in_e);

  assign wr_en_o   = tag_q[MAC_LAT-1].vld && tag_q[MAC_LAT-1].last;
  assign wr_addr_o = dst_q[MAC_LAT-1];
  assign wr_data_o = acc_d;

`ifndef SYNTHESIS
  a_wr_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (wr_data_o.ways < WAYS_MOD) && (wr_data_o.steps <= INF_STEPS))
    else $error("product entry written out of range");
`endif

endmodule

@@ sv/cmpmp_seq.sv @@
`timescale 1ns / 1ps

module cmpmp_seq import cmpmp_pkg::*; #(
  parameter  int unsigned DIM     = DIM_DEF,
  localparam int unsigned A_W     = $clog2(DIM * DIM),
  localparam int unsigned CNT_W   = $clog2(DIM),
  localparam int unsigned DRAIN_W = $clog2(MAC_LAT)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           go_i,
  output logic           busy_o,
  output logic           bank_o,
  output mac_tag_t       tag_o,
  output logic           diag_o,
  output logic [A_W-1:0] op_addr_o,
  output logic [A_W-1:0] prod_addr_o,
  output logic [A_W-1:0] dst_addr_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_e;

  localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(DIM - 1);
  localparam logic [DRAIN_W-1:0] DRAIN_LD = DRAIN_W'(MAC_LAT - 1);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   i_q, i_d;
  logic [CNT_W-1:0]   j_q, j_d;
  logic [CNT_W-1:0]   k_q, k_d;
  logic [DRAIN_W-1:0] drain_q, drain_d;
  logic               bank_q, bank_d;

  // k innermost, then j, then i
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    drain_d = drain_q;
    bank_d  = bank_q;
    case (state_q)
      S_IDLE: begin
        if (go_i) begin
          state_d = S_RUN;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
        end
      end
      S_RUN: begin
        if (k_q == CNT_LAST) begin
          k_d = '0;
          if (j_q == CNT_LAST) begin
            j_d = '0;
            if (i_q == CNT_LAST) begin
              state_d = S_DRAIN;
              drain_d = DRAIN_LD;
            end else begin
              i_d = i_q + 1'b1;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (drain_q == '0) begin
          state_d = S_IDLE;
          bank_d  = ~bank_q;
        end else begin
          drain_d = drain_q - 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      drain_q <= '0;
      bank_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      drain_q <= drain_d;
      bank_q  <= bank_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign bank_o      = bank_q;
  assign tag_o       = '{vld: (state_q == S_RUN), first: (k_q == '0), last: (k_q == CNT_LAST)};
  assign diag_o      = (k_q == j_q);
  assign op_addr_o   = A_W'(i_q * DIM + k_q);
  assign prod_addr_o = A_W'(k_q * DIM + j_q);
  assign dst_addr_o  = A_W'(i_q * DIM + j_q);

`ifndef SYNTHESIS
  a_bank_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(bank_q) |-> $past(state_q == S_DRAIN && drain_q == '0))
    else $error("bank flipped outside end of drain");

  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(go_i))
    else $error("sequencer started without a multiply word");
`endif

endmodule
